/* hdl/uart_rb_pkg.sv */
`timescale 1ns / 1ps

package uart_rb_pkg;

    // Operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;
    localparam logic [1:0] OP_TXRDY = 2'd3;

    // Host write outcomes
    localparam logic [1:0] WR_DIRECT  = 2'd0;
    localparam logic [1:0] WR_QUEUED  = 2'd1;
    localparam logic [1:0] WR_DROPPED = 2'd2;
    localparam logic [1:0] WR_NONE    = 2'd3;

    // Ring occupancy as seen by the control logic
    typedef struct packed {
        logic empty;
        logic full;
    } t_ring_stat;

    // Ring request from the control logic
    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_req;

endpackage

/* hdl/uart_rb_ram.sv */
`timescale 1ns / 1ps

module uart_rb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/uart_rb_ring.sv */
`timescale 1ns / 1ps

module uart_rb_ring #(
    parameter int DEPTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  uart_rb_pkg::t_ring_req i_req,
    input  logic [7:0]             i_wdata,
    output uart_rb_pkg::t_ring_stat o_stat,
    output logic [7:0]             o_rdata
);

    import uart_rb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [AW-1:0] n_head;
    logic [AW-1:0] n_tail;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] tail_inc;

    assign head_inc = (r_head == LAST) ? '0 : r_head + AW'(1);
    assign tail_inc = (r_tail == LAST) ? '0 : r_tail + AW'(1);

    // One slot stays unused so full and empty differ
    assign o_stat.empty = (r_head == r_tail);
    assign o_stat.full  = (tail_inc == r_head);

    assign n_head = i_req.pop  ? head_inc : r_head;
    assign n_tail = i_req.push ? tail_inc : r_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    uart_rb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.push),
        .i_waddr (r_tail),
        .i_wdata (i_wdata),
        .i_re    (i_req.pop),
        .i_raddr (r_head),
        .o_rdata (o_rdata)
    );

endmodule

/* hdl/uart_rx_tx_ring_buffers_top.sv */
`timescale 1ns / 1ps
// Serial port buffering: a receive ring and a transmit ring of DEPTH byte slots,
// each holding at most DEPTH-1 bytes.
// Command channel: an operation is taken on a rising edge with start high and
// busy low. busy stays low, so one operation may be issued every cycle.
// i_op selects host read, host write, byte received from the line, or
// transmitter-ready event; i_in_data and i_tx_ready go with it.
// Result channel: every operation yields exactly one result, shown for a single
// cycle with o_done high. The accepting edge updates the ring pointers, issues the
// slot read and loads the decision into stage one; the stage-two result register
// then registers the result once the ring memory has returned its byte.
// Throughput is one operation per cycle, set by the single write port and
// single registered read port of each ring memory.
// The receiver cannot stall; results are never held back.
// Reset (synchronous, active low) empties both rings and clears o_done. Slot
// contents are not cleared and need no clearing pass.
// A write to a full ring drops the byte and reports it: write_result for the
// transmit ring, o_rx_lost for the receive ring.

module uart_rx_tx_ring_buffers_top #(
    parameter int DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_op,
    input  logic [7:0] i_in_data,
    input  logic       i_tx_ready,
    output logic       o_done,
    output logic       o_read_valid,
    output logic [7:0] o_read_data,
    output logic       o_send_valid,
    output logic [7:0] o_send_data,
    output logic [1:0] o_write_result,
    output logic       o_rx_lost
);

    import uart_rb_pkg::*;

    logic       acc;
    t_ring_stat rx_stat;
    t_ring_stat tx_stat;
    t_ring_req  rx_req;
    t_ring_req  tx_req;
    logic [7:0] rx_rdata;
    logic [7:0] tx_rdata;

    logic       n_read_hit;
    logic       n_send_q;
    logic       n_send_dir;
    logic [1:0] n_wr_res;
    logic       n_lost;

    logic       r_v1;
    logic       r_read_hit;
    logic       r_send_q;
    logic       r_send_dir;
    logic [1:0] r_wr_res;
    logic       r_lost;
    logic [7:0] r_data;

    logic       r_done;
    logic       r_read_valid;
    logic [7:0] r_read_data;
    logic       r_send_valid;
    logic [7:0] r_send_data;
    logic [1:0] r_write_result;
    logic       r_rx_lost;

    assign busy = 1'b0;
    assign acc  = start && !busy;

    // Decide the operation against the current ring state
    always_comb begin
        n_read_hit = 1'b0;
        n_send_q   = 1'b0;
        n_send_dir = 1'b0;
        n_wr_res   = WR_NONE;
        n_lost     = 1'b0;
        rx_req     = '0;
        tx_req     = '0;
        unique case (i_op)
            OP_READ: begin
                n_read_hit = !rx_stat.empty;
            end
            OP_WRITE: begin
                if (tx_stat.empty && i_tx_ready) begin
                    n_send_dir = 1'b1;
                    n_wr_res   = WR_DIRECT;
                end else if (!tx_stat.full) begin
                    tx_req.push = acc;
                    n_wr_res    = WR_QUEUED;
                end else begin
                    n_wr_res = WR_DROPPED;
                end
            end
            OP_RX: begin
                rx_req.push = acc && !rx_stat.full;
                n_lost      = rx_stat.full;
            end
            OP_TXRDY: begin
                n_send_q = i_tx_ready && !tx_stat.empty;
            end
            default: begin
                n_wr_res = WR_NONE;
            end
        endcase
        rx_req.pop = acc && n_read_hit;
        tx_req.pop = acc && n_send_q;
    end

    uart_rb_ring #(
        .DEPTH (DEPTH)
    ) u_rx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rx_req),
        .i_wdata (i_in_data),
        .o_stat  (rx_stat),
        .o_rdata (rx_rdata)
    );

    uart_rb_ring #(
        .DEPTH (DEPTH)
    ) u_tx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tx_req),
        .i_wdata (i_in_data),
        .o_stat  (tx_stat),
        .o_rdata (tx_rdata)
    );

    // Stage one: decision held while the slot read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= acc;
        end
        r_read_hit <= n_read_hit;
        r_send_q   <= n_send_q;
        r_send_dir <= n_send_dir;
        r_wr_res   <= n_wr_res;
        r_lost     <= n_lost;
        r_data     <= i_in_data;
    end

    // Stage two: result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v1;
        end
        r_read_valid   <= r_read_hit;
        r_read_data    <= r_read_hit ? rx_rdata : 8'd0;
        r_send_valid   <= r_send_q || r_send_dir;
        r_send_data    <= r_send_dir ? r_data : (r_send_q ? tx_rdata : 8'd0);
        r_write_result <= r_wr_res;
        r_rx_lost      <= r_lost;
    end

    assign o_done         = r_done;
    assign o_read_valid   = r_read_valid;
    assign o_read_data    = r_read_data;
    assign o_send_valid   = r_send_valid;
    assign o_send_data    = r_send_data;
    assign o_write_result = r_write_result;
    assign o_rx_lost      = r_rx_lost;

endmodule

/* tb/uart_ring_checker.sv */
`timescale 1ns / 1ps

module uart_ring_checker
    import uart_rb_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [1:0] i_op,
    input  logic [7:0] i_in_data,
    input  logic       i_tx_ready,
    input  logic       o_done,
    input  logic       o_read_valid,
    input  logic [7:0] o_read_data,
    input  logic       o_send_valid,
    input  logic [7:0] o_send_data,
    input  logic [1:0] o_write_result,
    input  logic       o_rx_lost,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked,
    output int         o_drops
);

    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_data;
        logic       send_valid;
        logic [7:0] send_data;
        logic [1:0] write_result;
        logic       rx_lost;
    } t_uart_outcome;

    // Shadow copy of both rings
    logic [7:0]  rx_slot [DEPTH];
    logic [7:0]  tx_slot [DEPTH];
    int unsigned rx_rd, rx_wr, tx_rd, tx_wr;

    t_uart_outcome outcomes_due[$];
    int mismatches = 0;
    int checked    = 0;
    int drops      = 0;

    assign o_fail_count = mismatches;
    assign o_checked    = checked;
    assign o_drops      = drops;

    initial o_pending = 0;

    function automatic int unsigned ring_inc(int unsigned p);
        return (p + 1) % DEPTH;
    endfunction

    // Advances the shadow rings by one operation and returns what the block should report
    function automatic t_uart_outcome apply_op(logic [1:0] op, logic [7:0] data, logic rdy);
        t_uart_outcome r;
        r = '0;
        r.write_result = WR_NONE;
        case (op)
            OP_READ: begin
                if (rx_rd != rx_wr) begin
                    r.read_valid = 1'b1;
                    r.read_data  = rx_slot[rx_rd];
                    rx_rd = ring_inc(rx_rd);
                end
            end
            OP_WRITE: begin
                // queued bytes are never overtaken by a direct send
                if (tx_rd == tx_wr && rdy) begin
                    r.send_valid   = 1'b1;
                    r.send_data    = data;
                    r.write_result = WR_DIRECT;
                end else if (ring_inc(tx_wr) != tx_rd) begin
                    tx_slot[tx_wr] = data;
                    tx_wr = ring_inc(tx_wr);
                    r.write_result = WR_QUEUED;
                end else begin
                    r.write_result = WR_DROPPED;
                    drops++;
                end
            end
            OP_RX: begin
                if (ring_inc(rx_wr) != rx_rd) begin
                    rx_slot[rx_wr] = data;
                    rx_wr = ring_inc(rx_wr);
                end else begin
                    r.rx_lost = 1'b1;
                    drops++;
                end
            end
            OP_TXRDY: begin
                if (rdy && tx_rd != tx_wr) begin
                    r.send_valid = 1'b1;
                    r.send_data  = tx_slot[tx_rd];
                    tx_rd = ring_inc(tx_rd);
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_field(string name, int want, int got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_uart_outcome want;
        if (!i_rst_n) begin
            rx_rd = 0;
            rx_wr = 0;
            tx_rd = 0;
            tx_wr = 0;
            outcomes_due.delete();
        end else begin
            if (o_done) begin
                if (outcomes_due.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, got %0h",
                             $time, {o_read_valid, o_read_data, o_send_valid, o_send_data,
                                     o_write_result, o_rx_lost});
                    mismatches++;
                end else begin
                    want = outcomes_due.pop_front();
                    checked++;
                    if (o_read_valid !== want.read_valid)
                        report_field("read_valid", want.read_valid, o_read_valid);
                    if (o_read_data !== want.read_data)
                        report_field("read_data", want.read_data, o_read_data);
                    if (o_send_valid !== want.send_valid)
                        report_field("send_valid", want.send_valid, o_send_valid);
                    if (o_send_data !== want.send_data)
                        report_field("send_data", want.send_data, o_send_data);
                    if (o_write_result !== want.write_result)
                        report_field("write_result", want.write_result, o_write_result);
                    if (o_rx_lost !== want.rx_lost)
                        report_field("rx_lost", want.rx_lost, o_rx_lost);
                end
            end
            if (start && !busy)
                outcomes_due.push_back(apply_op(i_op, i_in_data, i_tx_ready));
        end
        o_pending <= outcomes_due.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import uart_rb_pkg::*;

    localparam int DEPTH       = 16;
    localparam int ITEMS       = 1850;
    localparam int STALL_LIMIT = 500;

    typedef enum int {
        MIX_TRAFFIC,
        RX_BURST,
        HOST_READS,
        TX_BURST,
        TX_DRAIN
    } t_traffic;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       start      = 1'b0;
    logic [1:0] i_op       = OP_READ;
    logic [7:0] i_in_data  = 8'h00;
    logic       i_tx_ready = 1'b0;
    logic       busy;
    logic       o_done;
    logic       o_read_valid;
    logic [7:0] o_read_data;
    logic       o_send_valid;
    logic [7:0] o_send_data;
    logic [1:0] o_write_result;
    logic       o_rx_lost;

    int fail_count, pending, checked, drops;
    int issued = 0;
    int op_count [4] = '{0, 0, 0, 0};
    int idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    uart_rx_tx_ring_buffers_top #(.DEPTH(DEPTH)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_in_data      (i_in_data),
        .i_tx_ready     (i_tx_ready),
        .o_done         (o_done),
        .o_read_valid   (o_read_valid),
        .o_read_data    (o_read_data),
        .o_send_valid   (o_send_valid),
        .o_send_data    (o_send_data),
        .o_write_result (o_write_result),
        .o_rx_lost      (o_rx_lost)
    );

    uart_ring_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_in_data      (i_in_data),
        .i_tx_ready     (i_tx_ready),
        .o_done         (o_done),
        .o_read_valid   (o_read_valid),
        .o_read_data    (o_read_data),
        .o_send_valid   (o_send_valid),
        .o_send_data    (o_send_data),
        .o_write_result (o_write_result),
        .o_rx_lost      (o_rx_lost),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_drops        (drops)
    );

    // Ends the run if neither channel moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Called at a clock edge; returns at the edge that takes the transfer
    task automatic issue(logic [1:0] op, logic [7:0] data, logic rdy, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_op       <= op;
        i_in_data  <= data;
        i_tx_ready <= rdy;
        do @(posedge i_clk); while (busy);
        issued++;
        op_count[op]++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [1:0] pick_op(t_traffic mode);
        if (mode == MIX_TRAFFIC || $urandom_range(0, 9) >= 8)
            return 2'($urandom_range(0, 3));
        case (mode)
            RX_BURST:   return OP_RX;
            HOST_READS: return OP_READ;
            TX_BURST:   return OP_WRITE;
            default:    return OP_TXRDY;
        endcase
    endfunction

    function automatic logic pick_ready(t_traffic mode);
        // hold the transmitter off while filling, keep it mostly ready while draining
        if (mode == TX_BURST)
            return $urandom_range(0, 3) == 0;
        if (mode == TX_DRAIN)
            return $urandom_range(0, 3) != 0;
        return 1'($urandom_range(0, 1));
    endfunction

    initial begin : stimulus
        t_traffic   mode;
        int         len;
        bit         idle_on;
        logic [1:0] op;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(OP_READ,  8'hA5, 1'b1, 0);   // read while empty
        issue(OP_TXRDY, 8'h3C, 1'b1, 0);   // ready event, nothing queued
        issue(OP_WRITE, 8'hFF, 1'b1, 0);   // straight to the line
        issue(OP_WRITE, 8'h00, 1'b0, 0);   // transmitter busy, queued
        issue(OP_WRITE, 8'h81, 1'b1, 1);   // ready but must queue behind
        issue(OP_TXRDY, 8'hFF, 1'b0, 0);   // not ready, nothing sent
        issue(OP_TXRDY, 8'h00, 1'b1, 0);
        issue(OP_TXRDY, 8'h7E, 1'b1, 3);
        issue(OP_TXRDY, 8'h00, 1'b1, 0);   // queue empty again
        issue(OP_RX,    8'h00, 1'b0, 0);
        issue(OP_RX,    8'hFF, 1'b1, 0);
        issue(OP_RX,    8'h5A, 1'b0, 2);
        issue(OP_READ,  8'h00, 1'b0, 0);
        issue(OP_READ,  8'hFF, 1'b1, 0);
        issue(OP_READ,  8'h12, 1'b0, 16);
        issue(OP_READ,  8'h34, 1'b1, 0);   // empty once more
        wait_drained();

        while (issued < ITEMS) begin
            mode    = t_traffic'($urandom_range(0, 4));
            len     = $urandom_range(12, 40);
            idle_on = $urandom_range(0, 2) != 0;
            for (int k = 0; k < len && issued < ITEMS; k++) begin
                op = pick_op(mode);
                issue(op, 8'($urandom_range(0, 255)), pick_ready(mode),
                      idle_on ? int'($urandom_range(0, 16)) : 0);
            end
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Issued %0d operations: %0d reads, %0d writes, %0d line bytes, %0d ready events",
                 issued, op_count[OP_READ], op_count[OP_WRITE], op_count[OP_RX],
                 op_count[OP_TXRDY]);
        $display("Checked %0d results, %0d bytes dropped on full rings", checked, drops);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
hdl/uart_rb_pkg.sv
hdl/uart_rb_ram.sv
hdl/uart_rb_ring.sv
hdl/uart_rx_tx_ring_buffers_top.sv
tb/uart_ring_checker.sv
tb/tb.sv
